### rtl/mnp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI note parser package
// Shared types and constants for the note message parser.
// ----------------------------------------------------------------------------
package mnp_pkg;

   localparam int ValueWidth    = 10;
   localparam int ChannelWidth  = 5;
   localparam int DataWidth     = 7;
   localparam int CsrIndexWidth = 1;
   localparam int CsrDataWidth  = 5;

   localparam logic [CsrIndexWidth-1:0] CSR_CHANNEL_SELECT = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_RELEASE_FORMAT = 1'b1;

   localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
   localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

   typedef struct packed {
      logic [DataWidth-1:0]    note_pitch;
      logic [DataWidth-1:0]    note_velocity;
      logic                    is_note_on;
      logic [1:0]              list_length;
      logic [ChannelWidth-1:0] channel_number;
      logic                    channel_reported;
   } result_type;

endpackage

### rtl/mnp_parse.sv
// ----------------------------------------------------------------------------
// MIDI note parser decode stage
// Holds the running status and channel state and decodes one byte per beat.
// ----------------------------------------------------------------------------
module mnp_parse (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic signed [mnp_pkg::ValueWidth-1:0] value,
   input  logic [mnp_pkg::ChannelWidth-1:0]    channel_select,
   input  logic                                release_format,
   output logic                                has_result,
   output mnp_pkg::result_type                 result
);

   typedef enum logic [1:0] {
      STATUS_NONE = 2'd0,
      STATUS_OFF  = 2'd1,
      STATUS_ON   = 2'd2
   } status_type;

   logic [mnp_pkg::ChannelWidth-1:0] applied_ff, applied_in;
   logic                             omni_ff, omni_in;
   logic [3:0]                       current_ff, current_in;
   status_type                       status_ff, status_in;
   logic                             pending_ff, pending_in;
   logic [mnp_pkg::DataWidth-1:0]    held_ff, held_in;
   logic                             match;

   always_comb begin
      applied_in = applied_ff;
      omni_in    = omni_ff;
      current_in = current_ff;
      status_in  = status_ff;
      pending_in = pending_ff;
      held_in    = held_ff;
      has_result = 1'b0;
      match      = 1'b0;
      if (!value[9]) begin
         if (channel_select != applied_ff) begin
            applied_in = channel_select;
            omni_in    = (channel_select == '0);
            if (channel_select != '0) begin
               current_in = 4'(channel_select - 5'd1);
            end
         end
         if (value[8]) begin
            status_in  = STATUS_NONE;
            pending_in = 1'b0;
         end else if (value[7]) begin
            if (value[7:3] == 5'b11111) begin
               // Real-time bytes leave the running status and pending data byte untouched.
            end else if (value[7:4] == mnp_pkg::KIND_NOTE_OFF ||
                         value[7:4] == mnp_pkg::KIND_NOTE_ON) begin
               if (omni_in) begin
                  current_in = value[3:0];
                  match      = 1'b1;
               end else begin
                  match = (applied_in == ({1'b0, value[3:0]} + 5'd1));
               end
               if (!match) begin
                  status_in = STATUS_NONE;
               end else if (value[7:4] == mnp_pkg::KIND_NOTE_ON) begin
                  status_in = STATUS_ON;
               end else begin
                  status_in = STATUS_OFF;
               end
               pending_in = 1'b0;
            end else begin
               status_in  = STATUS_NONE;
               pending_in = 1'b0;
            end
         end else if (pending_ff) begin
            has_result = 1'b1;
            pending_in = 1'b0;
         end else if (status_ff != STATUS_NONE) begin
            held_in    = value[6:0];
            pending_in = 1'b1;
         end
      end
   end

   always_comb begin
      result.note_pitch       = held_ff;
      result.note_velocity    = value[6:0];
      result.is_note_on       = (status_ff == STATUS_ON);
      result.list_length      = (release_format || status_ff != STATUS_ON) ? 2'd3 : 2'd2;
      result.channel_number   = {1'b0, current_in} + 5'd1;
      result.channel_reported = omni_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         applied_ff <= '0;
         omni_ff    <= 1'b1;
         current_ff <= '0;
         status_ff  <= STATUS_NONE;
         pending_ff <= 1'b0;
         held_ff    <= '0;
      end else if (step) begin
         applied_ff <= applied_in;
         omni_ff    <= omni_in;
         current_ff <= current_in;
         status_ff  <= status_in;
         pending_ff <= pending_in;
         held_ff    <= held_in;
      end
   end

endmodule

### rtl/mnp_out_reg.sv
// ----------------------------------------------------------------------------
// MIDI note parser result register
// Holds one finished note message until the result beat is taken.
// ----------------------------------------------------------------------------
module mnp_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mnp_pkg::result_type load_data,
   input  logic                rsp_ready,
   output logic                free,
   output logic                rsp_valid,
   output mnp_pkg::result_type rsp_data
);

   logic                valid_ff, valid_in;
   mnp_pkg::result_type data_ff;

   assign free      = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

### rtl/midi_note_parser.sv
// ----------------------------------------------------------------------------
// MIDI note parser
// Parses a MIDI byte stream and reports note-on and note-off messages.
//
//   Channel   Direction   Content
//   req_      in          one stream value per beat
//   rsp_      out         one completed note message per beat
//   csr_      in          register index and write data
//
// An input beat is registered in the input register, decoded there and its
// message, if any, is loaded into the result register. One beat is taken per
// cycle unless the decode stage waits, which it does only while it holds a
// message and the result register is full and not being taken. Reset is
// synchronous and clears state, CSRs and valid flags but not data registers.
// ----------------------------------------------------------------------------
module midi_note_parser (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [mnp_pkg::ValueWidth-1:0]   req_stream_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [mnp_pkg::DataWidth-1:0]           rsp_note_pitch,
   output logic [mnp_pkg::DataWidth-1:0]           rsp_note_velocity,
   output logic                                    rsp_is_note_on,
   output logic [1:0]                              rsp_list_length,
   output logic [mnp_pkg::ChannelWidth-1:0]        rsp_channel_number,
   output logic                                    rsp_channel_reported,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [mnp_pkg::CsrIndexWidth-1:0]       csr_index,
   input  logic [mnp_pkg::CsrDataWidth-1:0]        csr_data
);

   logic [mnp_pkg::ChannelWidth-1:0]        channel_select_ff;
   logic                                    release_format_ff;
   logic                                    in_valid_ff, in_valid_in;
   logic signed [mnp_pkg::ValueWidth-1:0]   in_value_ff;
   logic                                    has_result;
   logic                                    advance;
   logic                                    out_free;
   mnp_pkg::result_type                     result;
   mnp_pkg::result_type                     rsp_data;

   assign csr_ready   = 1'b1;
   assign advance     = in_valid_ff && (!has_result || out_free);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_select_ff <= '0;
         release_format_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mnp_pkg::CSR_CHANNEL_SELECT: channel_select_ff <= csr_data;
            mnp_pkg::CSR_RELEASE_FORMAT: release_format_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_value_ff <= req_stream_value;
      end
   end

   mnp_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .value          (in_value_ff),
      .channel_select (channel_select_ff),
      .release_format (release_format_ff),
      .has_result     (has_result),
      .result         (result)
   );

   mnp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && has_result),
      .load_data (result),
      .rsp_ready (rsp_ready),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_note_pitch       = rsp_data.note_pitch;
   assign rsp_note_velocity    = rsp_data.note_velocity;
   assign rsp_is_note_on       = rsp_data.is_note_on;
   assign rsp_list_length      = rsp_data.list_length;
   assign rsp_channel_number   = rsp_data.channel_number;
   assign rsp_channel_reported = rsp_data.channel_reported;

`ifndef SYNTHESIS
   a_off_is_triple: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_note_on |-> rsp_list_length == 2'd3)
      else $error("Note-off message without a three-element list.");

   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_channel_number != 5'd0 && rsp_channel_number <= 5'd16)
      else $error("Reported channel out of range.");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && has_result && rsp_valid && !rsp_ready)
      else $error("Input stalled without a blocked result.");
`endif

endmodule
